// ----- sv/mam_pkg.sv -----
// Shared types and constants for the matrix add/multiply block.
package mam_pkg;

   localparam int unsigned NUM_REGS = 5;

   localparam logic [2:0] REG_OP_MODE    = 3'd0;
   localparam logic [2:0] REG_LEFT_ROWS  = 3'd1;
   localparam logic [2:0] REG_LEFT_COLS  = 3'd2;
   localparam logic [2:0] REG_RIGHT_ROWS = 3'd3;
   localparam logic [2:0] REG_RIGHT_COLS = 3'd4;

   localparam logic MODE_ADD = 1'b0;
   localparam logic MODE_MUL = 1'b1;

   // Control handed from the sequencer to the cell row.
   typedef struct packed {
      logic clear;    // start a new result in every cell
      logic mac;      // accumulate product into cells
      logic add;      // load sum into the selected cell
      logic shift;    // move results one cell toward the tail
   } cell_ctrl_type;

endpackage

// ----- sv/mam_cell.sv -----
// One cell of the result row: a column of the right matrix and its accumulator.
module mam_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int DEPTH      = 8,
   parameter int ADDR_W     = 3
) (
   input  logic                       clock,
   input  mam_pkg::cell_ctrl_type     ctrl,
   input  logic                       sel,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [DATA_WIDTH-1:0]      wr_data,
   input  logic [ADDR_W-1:0]          rd_addr,
   input  logic [DATA_WIDTH-1:0]      a_value,
   input  logic [DATA_WIDTH-1:0]      prev_acc,
   output logic [DATA_WIDTH-1:0]      acc
);
   logic [DATA_WIDTH-1:0] col_mem [DEPTH];
   logic [DATA_WIDTH-1:0] b_rd_ff;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [DATA_WIDTH-1:0] prod;

   // Hold this cell's column of the right matrix; read one entry per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         col_mem[wr_addr] <= wr_data;
      end
      b_rd_ff <= col_mem[rd_addr];
   end

   always_comb begin
      prod   = a_value * b_rd_ff;
      acc_in = acc_ff;
      if (ctrl.shift) begin
         acc_in = prev_acc;
      end else if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.mac && sel) begin
         acc_in = acc_ff + prod;
      end else if (ctrl.add && sel) begin
         acc_in = a_value + b_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;
endmodule

// ----- sv/matrix_add_multiply.sv -----
// Top level: streamed integer matrix add / multiply.
//
// Usage: program op_mode and the four sizes over the csr_ port (APB style,
// registers at byte addresses 0,4,8,12,16) while the block is idle. Then
// pulse start with one element per cycle: the left matrix row-major, then
// the right matrix row-major. busy is high while results are being made.
// Each right element lands in the cell that owns its column. After the
// last right element the block computes one result row at a time in a
// row of MAX_DIM cells, each cell owning one output column. Both modes
// step through the left columns of each row with one left store read per
// cycle: multiply accumulates in every cell, add writes the sum into the
// cell of the current column. The row is then shifted out of the tail
// cell, one item per cycle on rsp_valid, with rsp_last_of_run marking the
// final item. An incompatible size yields one item with rsp_size_error.
// Reset returns the registers to their reset values and the loader to the
// left matrix. The receiver cannot stall: every item shows for one cycle.
module matrix_add_multiply #(
   parameter int MAX_DIM    = 8,
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_element,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_result_value,
   output logic               rsp_last_of_run,
   output logic               rsp_size_error,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
   localparam int DW    = $clog2(MAX_DIM + 1);
   localparam int IW    = $clog2(MAX_DIM) > 0 ? $clog2(MAX_DIM) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   localparam logic [2:0] ST_LOAD = 3'd0;
   localparam logic [2:0] ST_CLR  = 3'd1;
   localparam logic [2:0] ST_CALC = 3'd2;
   localparam logic [2:0] ST_OUT  = 3'd3;
   localparam logic [2:0] ST_ERR  = 3'd4;

   // ---------------- configuration registers ----------------
   logic       op_mode_ff;
   logic [3:0] lr_ff, lc_ff, rr_ff, rc_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff <= mam_pkg::MODE_MUL;
         lr_ff <= 4'd2; lc_ff <= 4'd2; rr_ff <= 4'd2; rc_ff <= 4'd2;
      end else if (wr_en) begin
         case (reg_idx)
            mam_pkg::REG_OP_MODE:    op_mode_ff <= csr_pwdata[0];
            mam_pkg::REG_LEFT_ROWS:  lr_ff <= csr_pwdata[3:0];
            mam_pkg::REG_LEFT_COLS:  lc_ff <= csr_pwdata[3:0];
            mam_pkg::REG_RIGHT_ROWS: rr_ff <= csr_pwdata[3:0];
            mam_pkg::REG_RIGHT_COLS: rc_ff <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         mam_pkg::REG_OP_MODE:    csr_prdata = {31'd0, op_mode_ff};
         mam_pkg::REG_LEFT_ROWS:  csr_prdata = {28'd0, lr_ff};
         mam_pkg::REG_LEFT_COLS:  csr_prdata = {28'd0, lc_ff};
         mam_pkg::REG_RIGHT_ROWS: csr_prdata = {28'd0, rr_ff};
         mam_pkg::REG_RIGHT_COLS: csr_prdata = {28'd0, rc_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   // Clamp a size to 1..MAX_DIM.
   function automatic logic [DW-1:0] eff(input logic [3:0] d);
      logic [DW-1:0] r;
      if (d == 4'd0) r = DW'(1);
      else if (32'(d) > MAX_DIM) r = DW'(MAX_DIM);
      else r = DW'(d);
      return r;
   endfunction

   logic [DW-1:0] lr, lc, rr, rc;
   assign lr = eff(lr_ff);
   assign lc = eff(lc_ff);
   assign rr = eff(rr_ff);
   assign rc = eff(rc_ff);

   logic [CW-1:0] left_size, right_size;
   assign left_size  = CW'(lr) * CW'(lc);
   assign right_size = CW'(rr) * CW'(rc);

   logic size_bad;
   assign size_bad = (op_mode_ff == mam_pkg::MODE_ADD) ? (lr != rr || lc != rc)
                                                      : (lc != rr);

   // ---------------- left element store ----------------
   logic [DATA_WIDTH-1:0] left_mem  [DEPTH];

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ld_right_ff, ld_right_in;
   logic [IW-1:0] row_ff, row_in;
   logic [IW-1:0] k_ff, k_in;
   logic [DW-1:0] ocnt_ff, ocnt_in;
   logic          accept;
   logic [DATA_WIDTH-1:0] elem;

   assign elem   = DATA_WIDTH'(req_element);
   assign accept = start & ~busy;
   assign busy   = (state_ff != ST_LOAD);

   // Left matrix: linear address; right matrix: row and column counters.
   logic [CW-1:0] w_idx;
   logic [IW-1:0] rw_row_ff, rw_col_ff;
   assign w_idx = cnt_ff;

   always_ff @(posedge clock) begin
      if (accept && !ld_right_ff && 32'(w_idx) < DEPTH) begin
         left_mem[w_idx[AW-1:0]] <= elem;
      end
   end

   // left operand read: address row*lc + k
   logic [AW-1:0]         a_addr;
   logic [IW-1:0]         b_addr;
   logic [DATA_WIDTH-1:0] a_rd_ff;
   logic                  a_sel_ff [MAX_DIM];
   mam_pkg::cell_ctrl_type ctrl;
   logic                  mac_dly_ff, add_dly_ff, clr_dly_ff;
   logic [CW-1:0]         base_ff, base_in;

   assign a_addr = AW'(base_ff + CW'(k_ff));
   // multiply walks the right rows; add reads the right row of the result row
   assign b_addr = (op_mode_ff == mam_pkg::MODE_ADD) ? row_ff : k_ff;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      ld_right_in = ld_right_ff;
      row_in      = row_ff;
      k_in        = k_ff;
      ocnt_in     = ocnt_ff;
      base_in     = base_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               cnt_in = cnt_ff + CW'(1);
               if (!ld_right_ff) begin
                  if (cnt_in >= left_size) begin
                     cnt_in = '0; ld_right_in = 1'b1;
                  end
               end else if (cnt_in >= right_size) begin
                  cnt_in = '0; ld_right_in = 1'b0;
                  row_in = '0; k_in = '0; base_in = '0;
                  state_in = size_bad ? ST_ERR : ST_CLR;
               end
            end
         end
         ST_CLR: begin
            k_in = '0;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (DW'(k_ff) + DW'(1) >= lc) begin
               state_in = ST_OUT;
               ocnt_in  = '0;
               k_in     = '0;
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         ST_OUT: begin
            // first cycle waits for the last accumulate to land
            ocnt_in = ocnt_ff + DW'(1);
            if (ocnt_ff == (op_mode_ff == mam_pkg::MODE_ADD ? lc : rc)) begin
               if (DW'(row_ff) + DW'(1) >= lr) begin
                  state_in = ST_LOAD;
               end else begin
                  row_in   = row_ff + IW'(1);
                  base_in  = base_ff + CW'(lc);
                  state_in = ST_CLR;
               end
            end
         end
         ST_ERR: state_in = ST_LOAD;
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         cnt_ff      <= '0;
         ld_right_ff <= 1'b0;
         row_ff      <= '0;
         k_ff        <= '0;
         ocnt_ff     <= '0;
         base_ff     <= '0;
         rw_row_ff   <= '0;
         rw_col_ff   <= '0;
         mac_dly_ff  <= 1'b0;
         add_dly_ff  <= 1'b0;
         clr_dly_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         ld_right_ff <= ld_right_in;
         row_ff      <= row_in;
         k_ff        <= k_in;
         ocnt_ff     <= ocnt_in;
         base_ff     <= base_in;
         // advance right-store write position along rows of rc columns
         if (accept && ld_right_ff) begin
            if (DW'(rw_col_ff) + DW'(1) >= rc) begin
               rw_col_ff <= '0;
               rw_row_ff <= rw_row_ff + IW'(1);
            end else begin
               rw_col_ff <= rw_col_ff + IW'(1);
            end
            if (ld_right_in == 1'b0) begin
               rw_row_ff <= '0; rw_col_ff <= '0;
            end
         end
         mac_dly_ff <= (state_ff == ST_CALC) && (op_mode_ff == mam_pkg::MODE_MUL);
         add_dly_ff <= (state_ff == ST_CALC) && (op_mode_ff == mam_pkg::MODE_ADD);
         clr_dly_ff <= (state_ff == ST_CLR);
      end
   end

   // Registered left read; every cell accumulates in multiply mode, only
   // the cell of column k takes the sum in add mode.
   always_ff @(posedge clock) begin
      a_rd_ff <= left_mem[a_addr];
      for (int c = 0; c < MAX_DIM; c++) begin
         a_sel_ff[c] <= (op_mode_ff == mam_pkg::MODE_MUL) || (k_ff == IW'(c));
      end
   end

   assign ctrl.clear = clr_dly_ff;
   assign ctrl.mac   = mac_dly_ff;
   assign ctrl.add   = add_dly_ff;
   assign ctrl.shift = (state_ff == ST_OUT) && (ocnt_ff != '0);

   // ---------------- cell row ----------------
   // Results shift from cell c+1 into cell c; cell 0 is the tail.
   logic [DATA_WIDTH-1:0] acc [MAX_DIM+1];
   assign acc[MAX_DIM] = '0;
   for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
      logic col_wr;
      assign col_wr = accept && ld_right_ff && (rw_col_ff == IW'(c));
      mam_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .DEPTH      (MAX_DIM),
         .ADDR_W     (IW)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .sel      (a_sel_ff[c]),
         .wr_en    (col_wr),
         .wr_addr  (rw_row_ff),
         .wr_data  (elem),
         .rd_addr  (b_addr),
         .a_value  (a_rd_ff),
         .prev_acc (acc[c+1]),
         .acc      (acc[c])
      );
   end

   // ---------------- result output ----------------
   logic               v_ff;
   logic signed [31:0] val_ff;
   logic               last_ff, err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= ctrl.shift || (state_ff == ST_ERR);
      end
      err_ff  <= (state_ff == ST_ERR);
      last_ff <= (state_ff == ST_ERR) ||
                 (ctrl.shift && state_in == ST_LOAD);
      val_ff  <= (state_ff == ST_ERR) ? 32'sd0
                 : 32'(signed'(acc[0]));
   end

   assign rsp_valid        = v_ff;
   assign rsp_result_value = val_ff;
   assign rsp_last_of_run  = last_ff;
   assign rsp_size_error   = err_ff;
endmodule

// ----- sv/mam_checker.sv -----
// Port-level checker for the matrix add/multiply block, with its bind.
module mam_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_last_of_run,
   input logic        rsp_size_error,
   input logic signed [31:0] rsp_result_value,
   input logic        csr_pready
);
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_size_error |-> rsp_last_of_run) else $error("error not last");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_size_error |-> rsp_result_value == 32'sd0)
      else $error("error value nonzero");
   a_out_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> $past(busy)) else $error("item while idle");
   a_ready: assert property (@(posedge clock) csr_pready) else $error("pready low");
endmodule

bind matrix_add_multiply mam_checker u_mam_checker (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_last_of_run(rsp_last_of_run),
   .rsp_size_error(rsp_size_error), .rsp_result_value(rsp_result_value),
   .csr_pready(csr_pready)
);

// ----- verif/tb_matrix_add_multiply.sv -----
// Testbench for matrix_add_multiply: directed and random matrix runs checked against a scoreboard model.
module tb_matrix_add_multiply;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] value;
      logic               last;
      logic               err;
   } mat_result_type;

   // Scoreboard: keep its own copy of the registers and stores, and queue the
   // results that each accepted element causes.
   class mat_scoreboard;
      logic        mode;
      logic [3:0]  dims [4];
      logic [31:0] left_mem  [64];
      logic [31:0] right_mem [64];
      int unsigned count;
      bit          on_right;
      mat_result_type pending [$];
      int          errors;

      function void clear_state();
         mode = mam_pkg::MODE_MUL;
         foreach (dims[i]) dims[i] = 4'd2;
         count = 0;
         on_right = 0;
         foreach (left_mem[i]) begin
            left_mem[i] = '0;
            right_mem[i] = '0;
         end
      endfunction

      function void write_reg(int idx, logic [31:0] val);
         if (idx == mam_pkg::REG_OP_MODE) mode = val[0];
         else dims[idx - 1] = val[3:0];
      endfunction

      function int unsigned clamp(logic [3:0] d);
         if (d == 0) return 1;
         if (d > 8) return 8;
         return d;
      endfunction

      function void push(logic [31:0] v, logic l, logic e);
         mat_result_type r;
         r.value = v;
         r.last = l;
         r.err = e;
         pending.push_back(r);
      endfunction

      function void note_element(logic [31:0] e);
         int unsigned lr, lc, rr, rc;
         logic [31:0] acc;
         lr = clamp(dims[0]);
         lc = clamp(dims[1]);
         rr = clamp(dims[2]);
         rc = clamp(dims[3]);
         if (!on_right) begin
            if (count < 64) left_mem[count] = e;
            count++;
            if (count >= lr * lc) begin
               count = 0;
               on_right = 1;
            end
            return;
         end
         if (count < 64) right_mem[count] = e;
         count++;
         if (count < rr * rc) return;
         count = 0;
         on_right = 0;
         if (mode == mam_pkg::MODE_ADD) begin
            if (lr != rr || lc != rc) begin
               push(0, 1, 1);
               return;
            end
            for (int i = 0; i < lr * lc; i++)
               push(left_mem[i] + right_mem[i], i + 1 == lr * lc, 0);
            return;
         end
         if (lc != rr) begin
            push(0, 1, 1);
            return;
         end
         for (int i = 0; i < lr; i++)
            for (int k = 0; k < rc; k++) begin
               acc = 0;
               for (int j = 0; j < lc; j++)
                  acc += left_mem[i * lc + j] * right_mem[j * rc + k];
               push(acc, i + 1 == lr && k + 1 == rc, 0);
            end
      endfunction

      // Print one mismatch line and count it.
      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_result(logic [31:0] v, logic l, logic e);
         mat_result_type r;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result value=%0h", v));
            return;
         end
         r = pending.pop_front();
         if (r.value !== v || r.last !== l || r.err !== e)
            report($sformatf("got v=%0h l=%0b e=%0b, want v=%0h l=%0b e=%0b",
                             v, l, e, r.value, r.last, r.err));
      endtask
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic signed [31:0] req_element = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_result_value;
   logic               rsp_last_of_run;
   logic               rsp_size_error;
   logic               csr_psel = 0;
   logic               csr_penable = 0;
   logic               csr_pwrite = 0;
   logic [4:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   mat_scoreboard board;
   int            idle_cycles;
   int            items_sent;
   bit            calm;
   int unsigned   cur_dims [4];

   matrix_add_multiply uut (.*);

   initial forever #2 clock = ~clock;

   // Check every strobed result at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_result(rsp_result_value, rsp_last_of_run, rsp_size_error);
   end

   // Watchdog: count cycles in which neither an item nor a result moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("[matrix_add_multiply] ERROR");
         $finish;
      end
   end

   // Write one register: setup cycle, then access cycle.
   task automatic write_csr(int idx, logic [31:0] val);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= 5'(idx * 4);
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      board.write_reg(idx, val);
   endtask

   // Program all registers; remember the clamped sizes for stimulus.
   task automatic configure(logic m, logic [3:0] lr, logic [3:0] lc,
                            logic [3:0] rr, logic [3:0] rc);
      write_csr(mam_pkg::REG_OP_MODE, {31'd0, m});
      write_csr(mam_pkg::REG_LEFT_ROWS, {28'd0, lr});
      write_csr(mam_pkg::REG_LEFT_COLS, {28'd0, lc});
      write_csr(mam_pkg::REG_RIGHT_ROWS, {28'd0, rr});
      write_csr(mam_pkg::REG_RIGHT_COLS, {28'd0, rc});
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      foreach (cur_dims[i]) cur_dims[i] = board.clamp(board.dims[i]);
   endtask

   // Offer one element; idle at random first, hold start until accepted.
   task automatic send_element(logic [31:0] e);
      while (!calm && $urandom_range(99) < 38) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_element <= e;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_element(e);
      items_sent++;
   endtask

   function automatic logic [31:0] rand_element(int style);
      case (style)
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'hffffffff;
         3: return 32'(int'($urandom_range(20)) - 10);
         default: return $urandom;
      endcase
   endfunction

   // Load both matrices for the current settings, then drain and settle.
   task automatic run_matrices(int style);
      int n;
      n = cur_dims[0] * cur_dims[1] + cur_dims[2] * cur_dims[3];
      for (int i = 0; i < n; i++)
         send_element(style < 0 ? rand_element($urandom_range(8)) : rand_element(style));
      start <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   initial begin
      logic [3:0] a, b, c, d;
      board = new();
      board.clear_state();
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: reset sizes, extremes, add, mismatched sizes, 0 and >8 clamp.
      calm = 1;
      run_matrices(0);
      configure(mam_pkg::MODE_ADD, 2, 2, 2, 2);
      run_matrices(1);
      configure(mam_pkg::MODE_ADD, 1, 1, 1, 1);
      run_matrices(2);
      configure(mam_pkg::MODE_ADD, 1, 2, 2, 1);
      run_matrices(-1);
      configure(mam_pkg::MODE_MUL, 1, 2, 3, 1);
      run_matrices(-1);
      configure(mam_pkg::MODE_MUL, 0, 15, 8, 1);
      run_matrices(0);

      // Random runs: mostly compatible sizes, some mismatched; mostly small.
      calm = 0;
      while (items_sent < 470) begin
         calm = ($urandom_range(9) == 0);
         if ($urandom_range(9) == 0) begin
            a = 4'd8; b = 4'd8;
         end else begin
            a = 4'($urandom_range(4)); b = 4'($urandom_range(4));
         end
         c = ($urandom_range(5) == 0) ? 4'($urandom_range(15)) : b;
         d = ($urandom_range(5) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 4));
         if ($urandom_range(1) == 0) begin
            if ($urandom_range(5) != 0) begin
               c = a; d = b;
            end
            configure(mam_pkg::MODE_ADD, a, b, c, d);
         end else begin
            configure(mam_pkg::MODE_MUL, a, b, c, d);
         end
         run_matrices(-1);
      end

      if (board.errors == 0 && board.pending.size() == 0)
         $display("[matrix_add_multiply] OK");
      else
         $display("[matrix_add_multiply] ERROR");
      $finish;
   end
endmodule
